// File: hw/rtl/part_model_table_matcher_assert.svh
// Assertion macros shared by the checker of the part model table matcher.
// Needs clk and rst_n in the scope of each use.
`ifndef PART_MODEL_TABLE_MATCHER_ASSERT_SVH
`define PART_MODEL_TABLE_MATCHER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define PMTM_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pmtm check failed");

// Antecedent at one edge requires consequent at the next edge.
`define PMTM_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmtm sequence check failed");

`endif

// File: hw/rtl/pmtm_pkg.sv
// Shared constants of the part model table matcher: sizes, opcodes, status, registers.
// No dependencies.
package pmtm_pkg;

    localparam int MAX_MODELS = 64;
    localparam int IDX_W      = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
    localparam int CNT_W      = $clog2(MAX_MODELS + 1);
    localparam int LOCKOUT_ITEMS = 4;

    localparam logic [1:0] OP_CLASSIFY = 2'd0;
    localparam logic [1:0] OP_COUNT    = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    localparam logic [3:0] ST_NEW      = 4'd0;
    localparam logic [3:0] ST_MATCHED  = 4'd1;
    localparam logic [3:0] ST_SEVERAL  = 4'd2;
    localparam logic [3:0] ST_NO_OBJ   = 4'd3;
    localparam logic [3:0] ST_FULL     = 4'd4;
    localparam logic [3:0] ST_COUNTED  = 4'd5;
    localparam logic [3:0] ST_LOCKED   = 4'd6;
    localparam logic [3:0] ST_NO_MODEL = 4'd7;
    localparam logic [3:0] ST_CLEARED  = 4'd8;

    localparam logic [1:0] REG_SIZE_TOL  = 2'd0;
    localparam logic [1:0] REG_AREA_TOL  = 2'd1;
    localparam logic [1:0] REG_DYNAMIC   = 2'd2;
    localparam logic [1:0] REG_TRAIN_TGT = 2'd3;

endpackage

// File: hw/rtl/part_model_table_matcher.sv
// Top level of the part model table matcher: FSM around one model memory.
// Depends on pmtm_pkg.
//
// One request at a time: in_stall stays high from acceptance until the result
// is loaded into the output register. A clear, a locked or modelless count and
// a no-object or several-object classify go straight to the walk; an accepted
// count first reads and writes back its model (S_C_RD, S_C_WR), a new model is
// stored in S_STORE, and a classify in dynamic mode compares the stored models
// one at a time (S_M_RD, S_M_A, S_M_B, S_M_C, S_M_D) until the first match.
// The walk (S_W_ST, S_W_RD, S_W_CHK) goes over the stored models and finds
// the trained count and the current pass count. A stalled result holds the
// next request off. All of it is set by the single read port of the model
// memory, one entry per step.
module part_model_table_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [11:0] obj_width,
    input  logic [11:0] obj_height,
    input  logic [23:0] obj_area,
    input  logic [7:0]  object_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [6:0]  cur_id,
    output logic [6:0]  stored_models,
    output logic [6:0]  trained_models,
    output logic [7:0]  pass_count
);

    localparam int IW = pmtm_pkg::IDX_W;
    localparam int CW = pmtm_pkg::CNT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M_RD  = 4'd1;
    localparam logic [3:0] S_M_A   = 4'd2;
    localparam logic [3:0] S_M_B   = 4'd3;
    localparam logic [3:0] S_M_C   = 4'd4;
    localparam logic [3:0] S_M_D   = 4'd5;
    localparam logic [3:0] S_STORE = 4'd6;
    localparam logic [3:0] S_C_RD  = 4'd7;
    localparam logic [3:0] S_C_WR  = 4'd8;
    localparam logic [3:0] S_W_ST  = 4'd9;
    localparam logic [3:0] S_W_RD  = 4'd10;
    localparam logic [3:0] S_W_CHK = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    typedef struct packed {
        logic [11:0] w;
        logic [11:0] h;
        logic [23:0] a;
        logic [7:0]  p;
    } model_t;

    model_t mem [pmtm_pkg::MAX_MODELS];
    model_t mem_q;
    model_t wr_entry;
    logic            mem_we;
    logic [IW-1:0]   wr_addr;
    logic [IW-1:0]   rd_addr;

    logic [11:0] size_tol_reg;
    logic [15:0] area_tol_reg;
    logic        dyn_reg;
    logic [7:0]  target_reg;

    logic [3:0]    state_reg, state_next;
    logic [11:0]   w_reg, h_reg;
    logic [23:0]   a_reg;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [2:0]    lock_reg, lock_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] trn_reg, trn_next;
    logic [7:0]    pc_reg, pc_next;
    logic [3:0]    res_reg, res_next;

    logic               size_ok_reg, size_ok_next;
    logic signed [26:0] p1_reg, p2_reg;
    logic signed [27:0] comp_reg;
    logic [27:0]        diff_reg;
    logic [42:0]        prod_reg;

    logic        ov_reg;
    logic [3:0]  o_status_reg;
    logic [6:0]  o_id_reg, o_stored_reg, o_trained_reg;
    logic [7:0]  o_pc_reg;

    logic accept;
    logic [CW-1:0] cur_m1;

    logic [12:0]        dh, dw;
    logic [11:0]        adh, adw;
    logic signed [13:0] d1, d2, half1, half2;
    logic signed [26:0] p1_c, p2_c;
    logic signed [27:0] comp_c;
    logic signed [28:0] dd_c;
    logic [27:0]        diff_c;
    logic [42:0]        prod_c;
    logic               fit;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cur_m1   = cur_reg - CW'(1);

    // size test and compensation products on the entry just read
    assign dh   = {1'b0, h_reg} - {1'b0, mem_q.h};
    assign dw   = {1'b0, w_reg} - {1'b0, mem_q.w};
    assign adh  = dh[12] ? 12'(-dh) : dh[11:0];
    assign adw  = dw[12] ? 12'(-dw) : dw[11:0];
    assign d1   = $signed({2'b00, mem_q.h}) - $signed({2'b00, h_reg}) - 14'sd1;
    assign d2   = $signed({2'b00, mem_q.w}) - $signed({2'b00, w_reg}) - 14'sd1;
    // truncate toward zero
    assign half1 = (d1 + $signed({13'b0, d1[13]})) >>> 1;
    assign half2 = (d2 + $signed({13'b0, d2[13]})) >>> 1;
    assign p1_c  = half1 * $signed({1'b0, w_reg});
    assign p2_c  = half2 * $signed({1'b0, h_reg});
    assign comp_c = $signed({4'b0000, a_reg}) + p1_reg + p2_reg;
    assign dd_c   = $signed({comp_reg[27], comp_reg}) - $signed({5'b00000, mem_q.a});
    assign diff_c = dd_c[28] ? 28'(-dd_c) : dd_c[27:0];
    assign prod_c = area_tol_reg * comp_reg[26:0];
    assign fit = size_ok_reg && (comp_reg[27] ||
                 (comp_reg != 28'sd0 && {diff_reg, 16'h0000} < {1'b0, prod_reg}));

    always_comb
    begin
        unique case (state_reg)
            S_C_RD:  rd_addr = cur_m1[IW-1:0];
            default: rd_addr = idx_reg[IW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_entry;
        end
        mem_q <= mem[rd_addr];
    end

    always_comb
    begin
        state_next   = state_reg;
        total_next   = total_reg;
        cur_next     = cur_reg;
        lock_next    = lock_reg;
        idx_next     = idx_reg;
        trn_next     = trn_reg;
        pc_next      = pc_reg;
        res_next     = res_reg;
        size_ok_next = size_ok_reg;
        mem_we       = 1'b0;
        wr_addr      = total_reg[IW-1:0];
        wr_entry     = '{w: w_reg, h: h_reg, a: a_reg, p: 8'd0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    unique case (opcode)
                        pmtm_pkg::OP_CLASSIFY:
                        begin
                            if (lock_reg != 3'd0)
                            begin
                                lock_next = lock_reg - 3'd1;
                            end
                            if (object_count == 8'd0)
                            begin
                                res_next   = pmtm_pkg::ST_NO_OBJ;
                                state_next = S_W_ST;
                            end
                            else if (!dyn_reg)
                            begin
                                if (object_count == 8'd1)
                                begin
                                    state_next = S_STORE;
                                end
                                else
                                begin
                                    res_next   = pmtm_pkg::ST_SEVERAL;
                                    state_next = S_W_ST;
                                end
                            end
                            else
                            begin
                                state_next = (total_reg == '0) ? S_STORE : S_M_RD;
                            end
                        end
                        pmtm_pkg::OP_COUNT:
                        begin
                            if (lock_reg != 3'd0)
                            begin
                                res_next   = pmtm_pkg::ST_LOCKED;
                                state_next = S_W_ST;
                            end
                            else if (cur_reg == '0 || cur_reg > total_reg)
                            begin
                                res_next   = pmtm_pkg::ST_NO_MODEL;
                                state_next = S_W_ST;
                            end
                            else
                            begin
                                state_next = S_C_RD;
                            end
                        end
                        pmtm_pkg::OP_CLEAR:
                        begin
                            total_next = '0;
                            res_next   = pmtm_pkg::ST_CLEARED;
                            state_next = S_W_ST;
                        end
                        default:
                        begin
                            // drop unused opcode, no result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_M_RD:
            begin
                state_next = S_M_A;
            end
            S_M_A:
            begin
                size_ok_next = (adh < size_tol_reg) && (adw < size_tol_reg);
                state_next   = S_M_B;
            end
            S_M_B:
            begin
                state_next = S_M_C;
            end
            S_M_C:
            begin
                state_next = S_M_D;
            end
            S_M_D:
            begin
                if (fit)
                begin
                    cur_next   = idx_reg + CW'(1);
                    res_next   = pmtm_pkg::ST_MATCHED;
                    state_next = S_W_ST;
                end
                else if (idx_reg + CW'(1) == total_reg)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_M_RD;
                end
            end
            S_STORE:
            begin
                if (total_reg == CW'(pmtm_pkg::MAX_MODELS))
                begin
                    res_next = pmtm_pkg::ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    total_next = total_reg + CW'(1);
                    cur_next   = total_reg + CW'(1);
                    res_next   = pmtm_pkg::ST_NEW;
                end
                state_next = S_W_ST;
            end
            S_C_RD:
            begin
                state_next = S_C_WR;
            end
            S_C_WR:
            begin
                mem_we     = 1'b1;
                wr_addr    = cur_m1[IW-1:0];
                wr_entry   = mem_q;
                if (mem_q.p != 8'hFF)
                begin
                    wr_entry.p = mem_q.p + 8'd1;
                end
                lock_next  = 3'(pmtm_pkg::LOCKOUT_ITEMS);
                res_next   = pmtm_pkg::ST_COUNTED;
                state_next = S_W_ST;
            end
            S_W_ST:
            begin
                idx_next   = '0;
                trn_next   = '0;
                pc_next    = 8'd0;
                state_next = (total_reg == '0) ? S_FIN : S_W_RD;
            end
            S_W_RD:
            begin
                state_next = S_W_CHK;
            end
            S_W_CHK:
            begin
                if (mem_q.p >= target_reg)
                begin
                    trn_next = trn_reg + CW'(1);
                end
                if (idx_reg + CW'(1) == cur_reg)
                begin
                    pc_next = mem_q.p;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = (idx_reg + CW'(1) == total_reg) ? S_FIN : S_W_RD;
            end
            S_FIN:
            begin
                if (!ov_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            total_reg    <= '0;
            cur_reg      <= '0;
            lock_reg     <= 3'd0;
            ov_reg       <= 1'b0;
            size_tol_reg <= 12'd10;
            area_tol_reg <= 16'd9830;
            dyn_reg      <= 1'b0;
            target_reg   <= 8'd3;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            cur_reg   <= cur_next;
            lock_reg  <= lock_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    pmtm_pkg::REG_SIZE_TOL:  size_tol_reg <= wr_data[11:0];
                    pmtm_pkg::REG_AREA_TOL:  area_tol_reg <= wr_data;
                    pmtm_pkg::REG_DYNAMIC:   dyn_reg      <= wr_data[0];
                    pmtm_pkg::REG_TRAIN_TGT: target_reg   <= wr_data[7:0];
                    default:                 dyn_reg      <= dyn_reg;
                endcase
            end
            if (state_reg == S_FIN && (!ov_reg || !out_stall))
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        trn_reg     <= trn_next;
        pc_reg      <= pc_next;
        res_reg     <= res_next;
        size_ok_reg <= size_ok_next;
        if (accept)
        begin
            w_reg   <= obj_width;
            h_reg   <= obj_height;
            a_reg   <= obj_area;
        end
        if (state_reg == S_M_A)
        begin
            p1_reg <= p1_c;
            p2_reg <= p2_c;
        end
        if (state_reg == S_M_B)
        begin
            comp_reg <= comp_c;
        end
        if (state_reg == S_M_C)
        begin
            diff_reg <= diff_c;
            prod_reg <= prod_c;
        end
        if (state_reg == S_FIN && (!ov_reg || !out_stall))
        begin
            o_status_reg  <= res_reg;
            o_id_reg      <= 7'(cur_reg);
            o_stored_reg  <= 7'(total_reg);
            o_trained_reg <= dyn_reg ? 7'(trn_reg) : 7'(total_reg);
            o_pc_reg      <= pc_reg;
        end
    end

    assign out_valid      = ov_reg;
    assign status         = o_status_reg;
    assign cur_id         = o_id_reg;
    assign stored_models  = o_stored_reg;
    assign trained_models = o_trained_reg;
    assign pass_count     = o_pc_reg;

endmodule

// File: hw/rtl/pmtm_checker.sv
// Port-level checks of the part model table matcher, bound to the top level.
// Depends on part_model_table_matcher_assert.svh and pmtm_pkg.
`include "part_model_table_matcher_assert.svh"

module pmtm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] status,
    input logic [6:0] cur_id,
    input logic [6:0] stored_models,
    input logic [6:0] trained_models
);

    logic counted_ok;

    // a counted result names a stored model
    assign counted_ok = status != pmtm_pkg::ST_COUNTED
                        || (cur_id != 7'd0 && cur_id <= stored_models);

    // hold a stalled result
    `PMTM_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `PMTM_ALWAYS(a_stored_max, !out_valid || stored_models <= 7'(pmtm_pkg::MAX_MODELS))
    `PMTM_ALWAYS(a_trained_le, !out_valid || trained_models <= stored_models)
    `PMTM_ALWAYS(a_counted_id, !out_valid || counted_ok)

endmodule

bind part_model_table_matcher pmtm_checker u_pmtm_checker (.*);

// File: bench/part_model_table_matcher_tb.sv
// Self-checking bench for the part model table matcher: directed table, then random traffic.
// Depends on pmtm_pkg and part_model_table_matcher.
module part_model_table_matcher_tb;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] w;
        logic [11:0] h;
        logic [23:0] a;
        logic [7:0]  cnt;
    } request_t;

    typedef struct packed {
        logic [3:0] st;
        logic [6:0] id;
        logic [6:0] total;
        logic [6:0] trained;
        logic [7:0] passes;
    } verdict_t;

    typedef struct packed {
        request_t   req;
        logic       fixed;   // expected result typed into the table
        verdict_t   res;
    } row_t;

    localparam int CYCLE_LIMIT = 1500000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = '0;
    logic [15:0] wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = '0;
    logic [11:0] obj_width = '0;
    logic [11:0] obj_height = '0;
    logic [23:0] obj_area = '0;
    logic [7:0]  object_count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  status;
    logic [6:0]  cur_id;
    logic [6:0]  stored_models;
    logic [6:0]  trained_models;
    logic [7:0]  pass_count;

    part_model_table_matcher i_dut (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .obj_width(obj_width), .obj_height(obj_height),
        .obj_area(obj_area), .object_count(object_count),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .cur_id(cur_id), .stored_models(stored_models),
        .trained_models(trained_models), .pass_count(pass_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor state
    logic [11:0] tbl_w [pmtm_pkg::MAX_MODELS];
    logic [11:0] tbl_h [pmtm_pkg::MAX_MODELS];
    logic [23:0] tbl_a [pmtm_pkg::MAX_MODELS];
    logic [7:0]  tbl_p [pmtm_pkg::MAX_MODELS];
    int          tbl_total;
    int          cur_model;
    int          lockout;
    logic [11:0] size_tol;
    logic [15:0] area_tol;
    logic        dyn_mode;
    logic [7:0]  train_tgt;

    verdict_t    pending_results[$];
    row_t        directed[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          matched_seen = 0;
    int          full_seen = 0;
    longint      cycles = 0;
    bit          quiet = 1'b0;
    bit          hold_off = 1'b0;

    function automatic bit area_close(int idx, request_t r);
        longint comp, diff;
        comp = longint'(r.a)
             + ((longint'(tbl_h[idx]) - longint'(r.h) - 1) / 2) * longint'(r.w)
             + ((longint'(tbl_w[idx]) - longint'(r.w) - 1) / 2) * longint'(r.h);
        if (comp < 0)
            return 1'b1;
        if (comp == 0)
            return 1'b0;
        diff = comp - longint'(tbl_a[idx]);
        if (diff < 0)
            diff = -diff;
        return diff * 65536 < longint'(area_tol) * comp;
    endfunction

    function automatic logic [3:0] add_model(request_t r);
        if (tbl_total >= pmtm_pkg::MAX_MODELS)
            return pmtm_pkg::ST_FULL;
        tbl_w[tbl_total] = r.w;
        tbl_h[tbl_total] = r.h;
        tbl_a[tbl_total] = r.a;
        tbl_p[tbl_total] = '0;
        tbl_total++;
        cur_model = tbl_total;
        return pmtm_pkg::ST_NEW;
    endfunction

    function automatic verdict_t classify_step(request_t r);
        verdict_t v;
        int       n;
        bit       hit;
        int       dh, dw;
        hit = 1'b0;
        v = '0;
        if (r.op == pmtm_pkg::OP_CLASSIFY)
        begin
            if (lockout > 0)
                lockout--;
            if (r.cnt == 0)
                v.st = pmtm_pkg::ST_NO_OBJ;
            else if (!dyn_mode)
                v.st = (r.cnt == 1) ? add_model(r) : pmtm_pkg::ST_SEVERAL;
            else
            begin
                for (int i = 0; i < tbl_total && !hit; i++)
                begin
                    dh = int'(r.h) - int'(tbl_h[i]);
                    dw = int'(r.w) - int'(tbl_w[i]);
                    if (dh < 0) dh = -dh;
                    if (dw < 0) dw = -dw;
                    if (dh < int'(size_tol) && dw < int'(size_tol) && area_close(i, r))
                    begin
                        hit = 1'b1;
                        cur_model = i + 1;
                    end
                end
                v.st = hit ? pmtm_pkg::ST_MATCHED : add_model(r);
            end
        end
        else if (r.op == pmtm_pkg::OP_COUNT)
        begin
            if (lockout != 0)
                v.st = pmtm_pkg::ST_LOCKED;
            else if (cur_model == 0 || cur_model > tbl_total)
                v.st = pmtm_pkg::ST_NO_MODEL;
            else
            begin
                if (tbl_p[cur_model-1] < 8'd255)
                    tbl_p[cur_model-1]++;
                lockout = pmtm_pkg::LOCKOUT_ITEMS;
                v.st = pmtm_pkg::ST_COUNTED;
            end
        end
        else
        begin
            tbl_total = 0;
            v.st = pmtm_pkg::ST_CLEARED;
        end
        n = 0;
        for (int i = 0; i < tbl_total; i++)
            if (!dyn_mode || tbl_p[i] >= train_tgt)
                n++;
        v.id = cur_model[6:0];
        v.total = tbl_total[6:0];
        v.trained = n[6:0];
        v.passes = (cur_model >= 1 && cur_model <= tbl_total) ? tbl_p[cur_model-1] : '0;
        return v;
    endfunction

    // Drive one request and wait for it to be accepted; the predictor runs on acceptance.
    // in_valid stays up between back-to-back requests; drop it only for a gap.
    task automatic send_request(request_t r, bit fixed, verdict_t want);
        verdict_t v;
        int       gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= r.op;
        obj_width <= r.w;
        obj_height <= r.h;
        obj_area <= r.a;
        object_count <= r.cnt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (r.op != 2'd3)
        begin
            v = classify_step(r);
            if (fixed && v != want)
                $display("table row disagrees with predictor: op %0d", r.op);
            pending_results.insert(pending_results.size(), fixed ? want : v);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            pmtm_pkg::REG_SIZE_TOL:  size_tol = val[11:0];
            pmtm_pkg::REG_AREA_TOL:  area_tol = val;
            pmtm_pkg::REG_DYNAMIC:   dyn_mode = val[0];
            default:                 train_tgt = val[7:0];
        endcase
        @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // allow for an unused opcode still in flight
        repeat (500) @(posedge clk);
    endtask

    function automatic request_t random_request(int maxdim);
        request_t r;
        int       k;
        r.w = 12'($urandom_range(1, maxdim));
        r.h = 12'($urandom_range(1, maxdim));
        r.a = 24'($urandom_range(0, r.w * r.h + 50));
        r.cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'd1;
        k = $urandom_range(0, 99);
        r.op = (k < 60) ? pmtm_pkg::OP_CLASSIFY : (k < 85) ? pmtm_pkg::OP_COUNT :
               (k < 97) ? pmtm_pkg::OP_CLEAR : 2'd3;
        if ($urandom_range(0, 19) == 0)
        begin
            r.w = 12'($urandom);
            r.h = 12'($urandom);
            r.a = 24'($urandom);
        end
        return r;
    endfunction

    // Check results against the oldest expectation
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (status == pmtm_pkg::ST_MATCHED) matched_seen <= matched_seen + 1;
            if (status == pmtm_pkg::ST_FULL) full_seen <= full_seen + 1;
            if (pending_results.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result: status %0d id %0d", status, cur_id);
            end
            else
            begin
                if ({status, cur_id, stored_models, trained_models, pass_count}
                    != pending_results[0])
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                 pending_results[0].st, pending_results[0].id,
                                 pending_results[0].total, pending_results[0].trained,
                                 pending_results[0].passes, status, cur_id,
                                 stored_models, trained_models, pass_count);
                end
                void'(pending_results.pop_front());
            end
        end
    end

    // Receiver stall: random bursts, none while quiet, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (quiet)
            out_stall <= 1'b0;
        else if (out_stall)
            out_stall <= ($urandom_range(0, 9) != 0) && ($urandom_range(0, 3) != 0);
        else
            out_stall <= ($urandom_range(0, 7) == 0);
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic row_t mk(logic [1:0] op, int w, int h, int a, int cnt,
                                bit fixed, verdict_t v);
        row_t r;
        r.req.op = op;
        r.req.w = 12'(w);
        r.req.h = 12'(h);
        r.req.a = 24'(a);
        r.req.cnt = 8'(cnt);
        r.fixed = fixed;
        r.res = v;
        return r;
    endfunction

    function automatic void add_row(row_t r);
        directed.insert(directed.size(), r);
    endfunction

    initial
    begin
        request_t r;
        int       n;
        tbl_total = 0;
        cur_model = 0;
        lockout = 0;
        size_tol = 12'd10;
        area_tol = 16'd9830;
        dyn_mode = 1'b0;
        train_tgt = 8'd3;
        for (int i = 0; i < pmtm_pkg::MAX_MODELS; i++)
        begin
            tbl_w[i] = '0; tbl_h[i] = '0; tbl_a[i] = '0; tbl_p[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // status, id, total, trained, passes
        add_row(mk(pmtm_pkg::OP_COUNT, 0, 0, 0, 0, 1,
                   {pmtm_pkg::ST_NO_MODEL, 7'd0, 7'd0, 7'd0, 8'd0}));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 5, 5, 5, 0, 1,
                   {pmtm_pkg::ST_NO_OBJ, 7'd0, 7'd0, 7'd0, 8'd0}));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 5, 5, 5, 255, 1,
                   {pmtm_pkg::ST_SEVERAL, 7'd0, 7'd0, 7'd0, 8'd0}));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 4095, 4095, 16777215, 1, 1,
                   {pmtm_pkg::ST_NEW, 7'd1, 7'd1, 7'd1, 8'd0}));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 0, 0, 0, 1, 1,
                   {pmtm_pkg::ST_NEW, 7'd2, 7'd2, 7'd2, 8'd0}));
        add_row(mk(pmtm_pkg::OP_COUNT, 0, 0, 0, 0, 1,
                   {pmtm_pkg::ST_COUNTED, 7'd2, 7'd2, 7'd2, 8'd1}));
        add_row(mk(pmtm_pkg::OP_COUNT, 0, 0, 0, 0, 1,
                   {pmtm_pkg::ST_LOCKED, 7'd2, 7'd2, 7'd2, 8'd1}));
        add_row(mk(2'd3, 1, 1, 1, 1, 0, '0));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 100, 50, 5000, 1, 0, '0));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 2730, 1365, 11184810, 170, 0, '0));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 1365, 2730, 5592405, 85, 0, '0));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 7, 7, 49, 1, 0, '0));
        add_row(mk(pmtm_pkg::OP_COUNT, 0, 0, 0, 0, 0, '0));
        add_row(mk(pmtm_pkg::OP_CLEAR, 0, 0, 0, 0, 1,
                   {pmtm_pkg::ST_CLEARED, 7'd4, 7'd0, 7'd0, 8'd0}));
        add_row(mk(pmtm_pkg::OP_COUNT, 0, 0, 0, 0, 0, '0));
        foreach (directed[i])
            send_request(directed[i].req, directed[i].fixed, directed[i].res);
        drain();

        // Dynamic mode: matches and zero compensated area
        write_reg(pmtm_pkg::REG_DYNAMIC, 16'd1);
        write_reg(pmtm_pkg::REG_TRAIN_TGT, 16'd1);
        directed.delete();
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 100, 50, 5000, 1, 0, '0));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 101, 51, 5050, 3, 0, '0));
        add_row(mk(pmtm_pkg::OP_COUNT, 0, 0, 0, 0, 0, '0));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 100, 50, 0, 1, 0, '0));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 4, 4, 0, 1, 0, '0));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 4, 4, 0, 1, 0, '0));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 1, 1, 0, 1, 0, '0));
        add_row(mk(pmtm_pkg::OP_CLASSIFY, 1, 1, 0, 1, 0, '0));
        foreach (directed[i])
            send_request(directed[i].req, 1'b0, '0);
        drain();

        // Random phases over register settings, extremes included
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin
                    write_reg(pmtm_pkg::REG_SIZE_TOL, 16'd10);
                    write_reg(pmtm_pkg::REG_AREA_TOL, 16'd9830);
                end
                1: begin
                    write_reg(pmtm_pkg::REG_SIZE_TOL, 16'd4095);
                    write_reg(pmtm_pkg::REG_AREA_TOL, 16'hFFFF);
                    write_reg(pmtm_pkg::REG_TRAIN_TGT, 16'd255);
                end
                2: begin
                    write_reg(pmtm_pkg::REG_SIZE_TOL, 16'd0);
                    write_reg(pmtm_pkg::REG_AREA_TOL, 16'd0);
                    write_reg(pmtm_pkg::REG_DYNAMIC, 16'd0);
                    write_reg(pmtm_pkg::REG_TRAIN_TGT, 16'd0);
                end
                3: begin
                    write_reg(pmtm_pkg::REG_SIZE_TOL, 16'hFFFF);
                    write_reg(pmtm_pkg::REG_DYNAMIC, 16'd1);
                    write_reg(pmtm_pkg::REG_AREA_TOL, 16'($urandom));
                end
                default: begin
                    write_reg(pmtm_pkg::REG_SIZE_TOL, 16'($urandom_range(1, 40)));
                    write_reg(pmtm_pkg::REG_AREA_TOL, 16'($urandom_range(1000, 30000)));
                    write_reg(pmtm_pkg::REG_DYNAMIC, 16'($urandom_range(0, 1)));
                    write_reg(pmtm_pkg::REG_TRAIN_TGT, 16'($urandom_range(0, 4)));
                end
            endcase
            n = (phase == 2) ? 130 : 100;
            if (phase == 5)
                quiet = 1'b1;
            for (int k = 0; k < n; k++)
            begin
                r = random_request((phase == 2) ? 4095 : 60);
                if (phase == 1 && k == 50)
                begin
                    // hold the output while requests keep coming
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (400) @(posedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                send_request(r, 1'b0, '0);
            end
            drain();
        end

        $display("Covered %0d results, %0d matches, %0d table-full cases over six settings.",
                 results_seen, matched_seen, full_seen);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/pmtm_pkg.sv
hw/rtl/part_model_table_matcher.sv
hw/rtl/pmtm_checker.sv
bench/part_model_table_matcher_tb.sv
